### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the Euler-to-quaternion block.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define E2Q_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define E2Q_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/e2q_pkg.sv
// Package for the Euler-to-quaternion block: widths, fixed-point constants,
// the CORDIC arctangent table and the Q30 product rounding.
// No dependencies.
`default_nettype none

package e2q_pkg;

	// Build-time choices
	localparam int CORDIC_ITERATIONS = 16;
	localparam int RESULT_WIDTH      = 16;
	localparam int MAX_STEPS         = 30;
	localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > MAX_STEPS) ?
		MAX_STEPS : CORDIC_ITERATIONS;

	// Angle format: half angle in 1/128 degree
	localparam int ANGLE_W            = 17;
	localparam int RED_W              = 19;
	localparam int TURN_UNITS         = 46080;
	localparam int HALF_TURN_UNITS    = 23040;
	localparam int QUARTER_TURN_UNITS = 11520;
	localparam int TMAG_W             = 14;

	// Phase = |t| * 3373259426 / 23040, split as |t|*146408 + |t|*19106/23040.
	// The low part divides by 512 with a shift and by 45 with a reciprocal.
	localparam int PHASE_HI_MULT = 146408;
	localparam int PHASE_LO_MULT = 19106;
	localparam int HI_W          = 31;
	localparam int LO_PROD_W     = 28;
	localparam int LOW_SHIFT     = 9;
	localparam int M_W           = 19;
	localparam int LOW_DIV       = 45;
	localparam int RECIP_45      = 745654;
	localparam int RECIP_SHIFT   = 25;
	localparam int QP_W          = 40;
	localparam int QE_W          = 14;

	// CORDIC datapath, Q30
	localparam int FRAC   = 30;
	localparam int X_W    = 33;
	localparam int Z_W    = 33;
	localparam logic signed [X_W-1:0] CORDIC_X0 = 33'sd652032874;
	localparam int TRIG_W = 32;

	// Pipeline depth
	localparam int PREP_STAGES    = 4;
	localparam int SINCOS_STAGES  = PREP_STAGES + CORDIC_STEPS;
	localparam int PRODUCT_STAGES = 3;
	localparam int NUM_STAGES     = SINCOS_STAGES + PRODUCT_STAGES;

	// Stream widths
	localparam int IN_TDATA_W  = ((3 * ANGLE_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((4 * RESULT_WIDTH + 7) / 8) * 8;

	// Cosine and sine of one angle, Q30
	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

	// Arctangent of 2^-i in radians, Q30
	function automatic logic signed [Z_W-1:0] atan_q30(input int i);
		case (i)
			0:       atan_q30 = 33'sd843314857;
			1:       atan_q30 = 33'sd497837829;
			2:       atan_q30 = 33'sd263043837;
			3:       atan_q30 = 33'sd133525159;
			4:       atan_q30 = 33'sd67021687;
			5:       atan_q30 = 33'sd33543516;
			6:       atan_q30 = 33'sd16775851;
			7:       atan_q30 = 33'sd8388437;
			8:       atan_q30 = 33'sd4194283;
			9:       atan_q30 = 33'sd2097149;
			10:      atan_q30 = 33'sd1048576;
			default: atan_q30 = Z_W'(longint'(1) << (FRAC - i));
		endcase
	endfunction

	// Q30 times Q30, rounded half up back to Q30
	function automatic logic signed [TRIG_W-1:0] mul_q30(
		input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b
	);
		logic signed [2*TRIG_W-1:0] p;
		p = a * b;
		p = p + ((2*TRIG_W)'(longint'(1) << (FRAC - 1)));
		mul_q30 = p[TRIG_W-1+FRAC:FRAC];
	endfunction

endpackage

`default_nettype wire

### rtl/euler_to_quaternion_unit.sv
// Euler angles (x-y-z) to a saturated fixed-point quaternion, fully pipelined.
// Depends on e2q_pkg, e2q_sincos and assert_macros.svh.
//
// Takes one item per clock while the output is not stalled and returns one
// result per item, in order. The pipeline has 4 reduction stages, one stage
// per CORDIC iteration (16 by default) and 3 product and rounding stages; the
// CORDIC iteration count sets its depth. Every stage has its own valid bit and
// moves whenever the stage after it has room, so bubbles close up and, while
// any stage is empty, input keeps taking items while a result waits at output.
// s_axis_tdata holds angle_x, angle_y, angle_z (17-bit signed, 1/64 degree);
// m_axis_tdata holds quat_x, quat_y, quat_z, quat_w (signed Q1.15, saturated).
// There is no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module euler_to_quaternion_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// angle_x [16:0], angle_y [33:17], angle_z [50:34], zero pad above
	input  wire logic [e2q_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// quat_x, quat_y, quat_z, quat_w from bit 0 up, RESULT_WIDTH bits each
	output logic [e2q_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

	localparam int NS  = e2q_pkg::NUM_STAGES;
	localparam int P1  = e2q_pkg::SINCOS_STAGES;
	localparam int RW  = e2q_pkg::RESULT_WIDTH;
	localparam int TW  = e2q_pkg::TRIG_W;
	localparam int V_W = TW + 1;
	localparam int R_W = V_W + 1;
	localparam int FRAC_OUT = RW - 1;
	localparam int SH = (FRAC_OUT < e2q_pkg::FRAC) ? e2q_pkg::FRAC - FRAC_OUT : 1;
	localparam logic signed [R_W-1:0] ROUND_ADD = R_W'(longint'(1) << (SH - 1));
	localparam logic signed [R_W-1:0] SAT_HI = R_W'((longint'(1) << FRAC_OUT) - 1);
	localparam logic signed [R_W-1:0] SAT_LO = -SAT_HI - R_W'(1);

	// Stage valid bits and enables: a stage loads when empty or draining
	logic [NS-1:0] valid_s;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !valid_s[NS-1] || m_axis_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[0]) begin
				valid_s[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = valid_s[NS-1];

	// Sine and cosine of the three half angles
	e2q_pkg::trig_t tx, ty, tz;

	e2q_sincos u_sc_x (
		.clk   (clk),
		.en    (en[P1-1:0]),
		.angle (s_axis_tdata[e2q_pkg::ANGLE_W-1:0]),
		.trig  (tx)
	);

	e2q_sincos u_sc_y (
		.clk   (clk),
		.en    (en[P1-1:0]),
		.angle (s_axis_tdata[2*e2q_pkg::ANGLE_W-1:e2q_pkg::ANGLE_W]),
		.trig  (ty)
	);

	e2q_sincos u_sc_z (
		.clk   (clk),
		.en    (en[P1-1:0]),
		.angle (s_axis_tdata[3*e2q_pkg::ANGLE_W-1:2*e2q_pkg::ANGLE_W]),
		.trig  (tz)
	);

	// Product stage 1: pairwise y-z products
	logic signed [TW-1:0] cycz_s1, sysz_s1, sycz_s1, cysz_s1, cx_s1, sx_s1;

	always_ff @(posedge clk) begin
		if (en[P1]) begin
			cycz_s1 <= e2q_pkg::mul_q30(ty.cos_v, tz.cos_v);
			sysz_s1 <= e2q_pkg::mul_q30(ty.sin_v, tz.sin_v);
			sycz_s1 <= e2q_pkg::mul_q30(ty.sin_v, tz.cos_v);
			cysz_s1 <= e2q_pkg::mul_q30(ty.cos_v, tz.sin_v);
			cx_s1   <= tx.cos_v;
			sx_s1   <= tx.sin_v;
		end
	end

	// Product stage 2: triple products
	logic signed [TW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2, pg_s2, ph_s2;

	always_ff @(posedge clk) begin
		if (en[P1+1]) begin
			pa_s2 <= e2q_pkg::mul_q30(sx_s1, cycz_s1);
			pb_s2 <= e2q_pkg::mul_q30(cx_s1, sysz_s1);
			pc_s2 <= e2q_pkg::mul_q30(cx_s1, sycz_s1);
			pd_s2 <= e2q_pkg::mul_q30(sx_s1, cysz_s1);
			pe_s2 <= e2q_pkg::mul_q30(cx_s1, cysz_s1);
			pf_s2 <= e2q_pkg::mul_q30(sx_s1, sycz_s1);
			pg_s2 <= e2q_pkg::mul_q30(cx_s1, cycz_s1);
			ph_s2 <= e2q_pkg::mul_q30(sx_s1, sysz_s1);
		end
	end

	// Round Q30 down to the output fraction and saturate
	function automatic logic [RW-1:0] finish(input logic signed [V_W-1:0] v);
		logic signed [R_W-1:0] r;
		if (FRAC_OUT < e2q_pkg::FRAC) begin
			r = (R_W'(v) + ROUND_ADD) >>> SH;
		end else if (FRAC_OUT == e2q_pkg::FRAC) begin
			r = R_W'(v);
		end else begin
			r = R_W'(v) <<< 1;
		end
		if (r > SAT_HI) begin
			r = SAT_HI;
		end
		if (r < SAT_LO) begin
			r = SAT_LO;
		end
		finish = RW'(r);
	endfunction

	// Product stage 3: combine, round, saturate into the output register
	logic [RW-1:0] quat_x_s3, quat_y_s3, quat_z_s3, quat_w_s3;

	always_ff @(posedge clk) begin
		if (en[P1+2]) begin
			quat_x_s3 <= finish(V_W'(pa_s2) - V_W'(pb_s2));
			quat_y_s3 <= finish(V_W'(pc_s2) + V_W'(pd_s2));
			quat_z_s3 <= finish(V_W'(pe_s2) - V_W'(pf_s2));
			quat_w_s3 <= finish(V_W'(pg_s2) + V_W'(ph_s2));
		end
	end

	assign m_axis_tdata = e2q_pkg::OUT_TDATA_W'({quat_w_s3, quat_z_s3, quat_y_s3, quat_x_s3});

	// Checks on the stage control
	`E2Q_ASSERT(a_accept_fills_first, (s_axis_tvalid && s_axis_tready) |=> valid_s[0], "accepted item did not enter stage one")
	`E2Q_ASSERT(a_empty_out_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
	`E2Q_ASSERT(a_held_first_kept, (valid_s[0] && !s_axis_tready) |=> valid_s[0], "held item dropped from stage one")
	`E2Q_NEVER(a_ready_with_full_stall, valid_s[0] && s_axis_tready && !en[1], "stage one overwritten while held")

endmodule

`default_nettype wire

### rtl/e2q_sincos.sv
// Sine and cosine of one half angle: range reduction, phase scaling and an
// unrolled rotation-mode CORDIC, one iteration per pipeline stage.
// Depends on e2q_pkg; stage enables come from the top level.
`default_nettype none

module e2q_sincos (
	input  wire logic                                   clk,
	input  wire logic [e2q_pkg::SINCOS_STAGES-1:0]      en,
	input  wire logic signed [e2q_pkg::ANGLE_W-1:0]     angle,
	output e2q_pkg::trig_t                              trig
);

	localparam int PS = e2q_pkg::PREP_STAGES;
	localparam int NC = e2q_pkg::CORDIC_STEPS;

	// Stage 1: reduce to one turn, then fold into a quarter turn
	logic signed [e2q_pkg::RED_W-1:0] v0, a1, a2, t0, t1;
	logic                             fold;
	logic [e2q_pkg::TMAG_W-1:0]       mag_s1;
	logic                             neg_s1, flip_s1;

	always_comb begin
		v0 = e2q_pkg::RED_W'(angle);
		a1 = (v0 < 0) ? v0 + e2q_pkg::RED_W'(e2q_pkg::TURN_UNITS) : v0;
		if (a1 < 0) begin
			a2 = a1 + e2q_pkg::RED_W'(e2q_pkg::TURN_UNITS);
		end else if (a1 >= e2q_pkg::TURN_UNITS) begin
			a2 = a1 - e2q_pkg::RED_W'(e2q_pkg::TURN_UNITS);
		end else begin
			a2 = a1;
		end
		t0 = (a2 >= e2q_pkg::HALF_TURN_UNITS) ?
			a2 - e2q_pkg::RED_W'(e2q_pkg::TURN_UNITS) : a2;
		fold = 1'b1;
		if (t0 > e2q_pkg::QUARTER_TURN_UNITS) begin
			t1 = e2q_pkg::RED_W'(e2q_pkg::HALF_TURN_UNITS) - t0;
		end else if (t0 < -e2q_pkg::QUARTER_TURN_UNITS) begin
			t1 = -e2q_pkg::RED_W'(e2q_pkg::HALF_TURN_UNITS) - t0;
		end else begin
			t1 = t0;
			fold = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_s1  <= e2q_pkg::TMAG_W'((t1 < 0) ? -t1 : t1);
			neg_s1  <= (t1 < 0);
			flip_s1 <= fold;
		end
	end

	// Stage 2: high and low parts of the phase product
	logic [e2q_pkg::LO_PROD_W-1:0] lo_prod;
	logic [e2q_pkg::HI_W-1:0]      hi_s2;
	logic [e2q_pkg::M_W-1:0]       m_s2;
	logic                          neg_s2, flip_s2;

	assign lo_prod = e2q_pkg::LO_PROD_W'(mag_s1) *
		e2q_pkg::LO_PROD_W'(e2q_pkg::PHASE_LO_MULT);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hi_s2   <= e2q_pkg::HI_W'(e2q_pkg::HI_W'(mag_s1) *
				e2q_pkg::HI_W'(e2q_pkg::PHASE_HI_MULT));
			m_s2    <= e2q_pkg::M_W'(lo_prod >> e2q_pkg::LOW_SHIFT);
			neg_s2  <= neg_s1;
			flip_s2 <= flip_s1;
		end
	end

	// Stage 3: quotient estimate by 45, low by at most one
	logic [e2q_pkg::QP_W-1:0] q_prod;
	logic [e2q_pkg::HI_W-1:0] hi_s3;
	logic [e2q_pkg::M_W-1:0]  m_s3;
	logic [e2q_pkg::QE_W-1:0] qe_s3;
	logic                     neg_s3, flip_s3;

	assign q_prod = e2q_pkg::QP_W'(m_s2) * e2q_pkg::QP_W'(e2q_pkg::RECIP_45);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			qe_s3   <= e2q_pkg::QE_W'(q_prod >> e2q_pkg::RECIP_SHIFT);
			hi_s3   <= hi_s2;
			m_s3    <= m_s2;
			neg_s3  <= neg_s2;
			flip_s3 <= flip_s2;
		end
	end

	// Stage 4: quotient correction and signed phase
	logic [e2q_pkg::M_W-1:0]  rem;
	logic [e2q_pkg::QE_W-1:0] q_fix;
	logic [e2q_pkg::HI_W-1:0] zmag;
	logic signed [e2q_pkg::Z_W-1:0] z_s4;
	logic                     flip_s4;

	always_comb begin
		rem   = m_s3 - e2q_pkg::M_W'(qe_s3 * e2q_pkg::M_W'(e2q_pkg::LOW_DIV));
		q_fix = (rem >= e2q_pkg::M_W'(e2q_pkg::LOW_DIV)) ? qe_s3 + 1'b1 : qe_s3;
		zmag  = hi_s3 + e2q_pkg::HI_W'(q_fix);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			z_s4    <= neg_s3 ? -e2q_pkg::Z_W'(zmag) : e2q_pkg::Z_W'(zmag);
			flip_s4 <= flip_s3;
		end
	end

	// CORDIC: one micro-rotation per stage
	logic signed [e2q_pkg::X_W-1:0] x_sc [NC];
	logic signed [e2q_pkg::X_W-1:0] y_sc [NC];
	logic signed [e2q_pkg::Z_W-1:0] z_sc [NC];
	logic                           flip_sc [NC];

	for (genvar k = 0; k < NC; k++) begin : g_iter
		logic signed [e2q_pkg::X_W-1:0] x_in, y_in;
		logic signed [e2q_pkg::Z_W-1:0] z_in;
		logic                           f_in;

		if (k == 0) begin : g_first
			assign x_in = e2q_pkg::CORDIC_X0;
			assign y_in = '0;
			assign z_in = z_s4;
			assign f_in = flip_s4;
		end else begin : g_next
			assign x_in = x_sc[k-1];
			assign y_in = y_sc[k-1];
			assign z_in = z_sc[k-1];
			assign f_in = flip_sc[k-1];
		end

		always_ff @(posedge clk) begin
			if (en[PS+k]) begin
				if (!z_in[e2q_pkg::Z_W-1]) begin
					x_sc[k] <= x_in - (y_in >>> k);
					y_sc[k] <= y_in + (x_in >>> k);
					z_sc[k] <= z_in - e2q_pkg::atan_q30(k);
				end else begin
					x_sc[k] <= x_in + (y_in >>> k);
					y_sc[k] <= y_in - (x_in >>> k);
					z_sc[k] <= z_in + e2q_pkg::atan_q30(k);
				end
				flip_sc[k] <= f_in;
			end
		end
	end

	// Folded angles take the negated cosine
	assign trig.cos_v = e2q_pkg::TRIG_W'(flip_sc[NC-1] ? -x_sc[NC-1] : x_sc[NC-1]);
	assign trig.sin_v = e2q_pkg::TRIG_W'(y_sc[NC-1]);

endmodule

`default_nettype wire
